FILE: src/step_dir_pulse_ramp_generator_assert.svh
// Assertion macros for the step/direction ramp generator.
// Included by the top level; relies on nothing else.
`ifndef STEP_DIR_PULSE_RAMP_GENERATOR_ASSERT_SVH
`define STEP_DIR_PULSE_RAMP_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("step/dir generator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("step/dir generator assertion failed");

`endif

FILE: src/sdp_pkg.sv
// Shared types and constants for the step/direction ramp generator.
// Used by the top level and the serial arithmetic units; depends on nothing.
package sdp_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DIV_WIDTH = 64;
   localparam int DIVISOR_WIDTH = 49;
   localparam int MUL_WIDTH = 32;
   localparam logic [31:0] US_PER_S = 32'd1000000;
   localparam logic [19:0] INTERVAL_MAX = 20'hFFFFF;

   localparam logic [1:0] CSR_PPR = 2'd0;
   localparam logic [1:0] CSR_MAX_VEL = 2'd1;
   localparam logic [1:0] CSR_MIN_FREQ = 2'd2;
   localparam logic [1:0] CSR_ACCEL = 2'd3;

   typedef struct packed {
      logic               mode;
      logic signed [31:0] target_velocity;
      logic [31:0]        now_us;
   } sdp_req_type;

   typedef struct packed {
      logic               pulse_level;
      logic               direction_level;
      logic [19:0]        edge_interval_us;
      logic               interval_valid;
      logic               is_stopped;
      logic               at_max_velocity;
      logic signed [31:0] actual_velocity;
   } sdp_rsp_type;

endpackage

FILE: src/sdp_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Uses widths from sdp_pkg; a zero divisor yields an all-ones quotient.
module sdp_div import sdp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIV_WIDTH-1:0]     dividend,
   input  logic [DIVISOR_WIDTH-1:0] divisor,
   output logic                     done,
   output logic [DIV_WIDTH-1:0]     quotient
);

   localparam int CNT_W = $clog2(DIV_WIDTH);

   logic [DIV_WIDTH-1:0]     dq_ff;
   logic [DIVISOR_WIDTH-1:0] rem_ff;
   logic [DIVISOR_WIDTH-1:0] den_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic                     busy_ff;
   logic                     done_ff;
   logic [DIVISOR_WIDTH:0]   trial;
   logic [DIVISOR_WIDTH:0]   diff;
   logic                     ge;

   assign trial = {rem_ff, dq_ff[DIV_WIDTH-1]};
   assign ge = trial >= {1'b0, den_ff};
   assign diff = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_WIDTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
         dq_ff <= {dq_ff[DIV_WIDTH-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quotient = dq_ff;

endmodule

FILE: src/sdp_mul.sv
// Shift-and-add multiplier that consumes one multiplier bit per cycle.
// Uses widths from sdp_pkg.
module sdp_mul import sdp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [MUL_WIDTH-1:0]   mcand,
   input  logic [MUL_WIDTH-1:0]   mplier,
   output logic                   done,
   output logic [2*MUL_WIDTH-1:0] product
);

   localparam int CNT_W = $clog2(MUL_WIDTH);

   logic [2*MUL_WIDTH-1:0] prod_ff;
   logic [MUL_WIDTH-1:0]   mcand_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   busy_ff;
   logic                   done_ff;
   logic [MUL_WIDTH:0]     sum;

   assign sum = {1'b0, prod_ff[2*MUL_WIDTH-1:MUL_WIDTH]}
              + (prod_ff[0] ? {1'b0, mcand_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MUL_WIDTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= {{MUL_WIDTH{1'b0}}, mplier};
         mcand_ff <= mcand;
      end else if (busy_ff) begin
         prod_ff <= {sum, prod_ff[MUL_WIDTH-1:1]};
      end
   end

   assign done = done_ff;
   assign product = prod_ff;

endmodule

FILE: src/step_dir_pulse_ramp_generator.sv
// Step/direction pulse generator with a linear velocity ramp (top level).
// Depends on sdp_pkg, sdp_div, sdp_mul and the assertion macro header.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   req_data (sdp_req_type)
//   rsp      out        rsp_valid / rsp_stall   rsp_data (sdp_rsp_type)
//   csr      in         csr_write_enable        csr_index, csr_write_data
//
// A target item or an edge item with the pulse high needs only the minimum velocity division.
// An edge item with the pulse low runs, in order, the minimum velocity division,
// the step product and division, the denominator product for a running generator only,
// and the interval division, all one bit per cycle.
// One item is in work at a time; the next is taken while a result waits.
// Reset is synchronous and restores the register defaults.
module step_dir_pulse_ramp_generator import sdp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  sdp_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output sdp_rsp_type rsp_data,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_write_data
);

`include "step_dir_pulse_ramp_generator_assert.svh"

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MINV  = 3'd1;
   localparam logic [2:0] S_STEPM = 3'd2;
   localparam logic [2:0] S_STEPD = 3'd3;
   localparam logic [2:0] S_DENM  = 3'd4;
   localparam logic [2:0] S_INTD  = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;

   logic [15:0] ppr_ff, minf_ff;
   logic [30:0] maxv_ff, accel_ff;

   logic [2:0]         state_ff, state_in;
   sdp_req_type        item_ff, item_in;
   logic signed [31:0] target_ff, target_in;
   logic signed [31:0] actual_ff, actual_in;
   logic               pulse_ff, pulse_in;
   logic               dir_ff, dir_in;
   logic               stopped_ff, stopped_in;
   logic [31:0]        last_ff, last_in;
   logic [31:0]        minv_ff, minv_in;
   logic [19:0]        interval_ff, interval_in;
   logic               ivalid_ff, ivalid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sdp_rsp_type        rsp_ff, rsp_in;

   logic                     div_start, div_done, mul_start, mul_done;
   logic [DIV_WIDTH-1:0]     div_dividend, div_quot;
   logic [DIVISOR_WIDTH-1:0] div_divisor;
   logic [MUL_WIDTH-1:0]     mul_mcand, mul_mplier;
   logic [2*MUL_WIDTH-1:0]   mul_prod;

   logic [15:0]        ppr_eff;
   logic [31:0]        abs_actual, abs_req, abs_new, elapsed;
   logic signed [32:0] max_ext;
   logic signed [32:0] ramp_diff;
   logic signed [31:0] ramp_a;

   sdp_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(div_divisor), .done(div_done), .quotient(div_quot)
   );

   sdp_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .mcand(mul_mcand),
      .mplier(mul_mplier), .done(mul_done), .product(mul_prod)
   );

   assign ppr_eff = (ppr_ff == 16'd0) ? 16'd1 : ppr_ff;
   assign abs_actual = actual_ff[31] ? 32'(-actual_ff) : 32'(actual_ff);
   assign abs_req = item_ff.target_velocity[31] ? 32'(-item_ff.target_velocity)
                                                : 32'(item_ff.target_velocity);
   assign max_ext = {2'b00, maxv_ff};
   assign elapsed = item_ff.now_us - last_ff;

   // Ramp toward the target, clamped so the step never passes it.
   always_comb begin
      ramp_a = actual_ff;
      ramp_diff = '0;
      if (actual_ff < target_ff) begin
         ramp_diff = 33'(target_ff) - 33'(actual_ff);
         if (div_quot >= 64'(ramp_diff)) begin
            ramp_a = target_ff;
         end else begin
            ramp_a = actual_ff + signed'(div_quot[31:0]);
         end
      end else if (actual_ff > target_ff) begin
         ramp_diff = 33'(actual_ff) - 33'(target_ff);
         if (div_quot >= 64'(ramp_diff)) begin
            ramp_a = target_ff;
         end else begin
            ramp_a = actual_ff - signed'(div_quot[31:0]);
         end
      end
   end
   assign abs_new = ramp_a[31] ? 32'(-ramp_a) : 32'(ramp_a);

   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      target_in = target_ff;
      actual_in = actual_ff;
      pulse_in = pulse_ff;
      dir_in = dir_ff;
      stopped_in = stopped_ff;
      last_in = last_ff;
      minv_in = minv_ff;
      interval_in = interval_ff;
      ivalid_in = ivalid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      div_start = 1'b0;
      div_dividend = 64'({minf_ff, {FRAC_BITS{1'b0}}});
      div_divisor = DIVISOR_WIDTH'(ppr_eff);
      mul_start = 1'b0;
      mul_mcand = {1'b0, accel_ff};
      mul_mplier = elapsed;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               interval_in = '0;
               ivalid_in = 1'b0;
               div_start = 1'b1;
               state_in = S_MINV;
            end
         end
         S_MINV: begin
            if (div_done) begin
               minv_in = div_quot[31:0];
               if (!item_ff.mode) begin
                  if (33'(item_ff.target_velocity) > max_ext) begin
                     target_in = 32'(max_ext);
                  end else if (33'(item_ff.target_velocity) < -max_ext) begin
                     target_in = 32'(-max_ext);
                  end else if (abs_req < div_quot[31:0]) begin
                     target_in = '0;
                  end else begin
                     target_in = item_ff.target_velocity;
                  end
                  state_in = S_FIN;
               end else if (pulse_ff) begin
                  pulse_in = stopped_ff ? 1'b0 : ~pulse_ff;
                  dir_in = stopped_ff ? 1'b0 : (actual_ff > 0);
                  state_in = S_FIN;
               end else begin
                  last_in = item_ff.now_us;
                  mul_start = 1'b1;
                  state_in = S_STEPM;
               end
            end
         end
         S_STEPM: begin
            if (mul_done) begin
               div_dividend = mul_prod;
               div_divisor = DIVISOR_WIDTH'(US_PER_S);
               div_start = 1'b1;
               state_in = S_STEPD;
            end
         end
         S_STEPD: begin
            if (div_done) begin
               if (abs_new >= minv_ff) begin
                  actual_in = ramp_a;
                  stopped_in = 1'b0;
                  mul_mcand = abs_new;
                  mul_mplier = 32'(ppr_eff);
                  mul_start = 1'b1;
                  state_in = S_DENM;
               end else begin
                  actual_in = '0;
                  stopped_in = 1'b1;
                  pulse_in = 1'b0;
                  dir_in = 1'b0;
                  div_dividend = 64'(US_PER_S);
                  div_divisor = DIVISOR_WIDTH'({minf_ff, 1'b0});
                  div_start = 1'b1;
                  state_in = S_INTD;
               end
            end
         end
         S_DENM: begin
            if (mul_done) begin
               div_dividend = 64'(US_PER_S) << FRAC_BITS;
               div_divisor = {mul_prod[DIVISOR_WIDTH-2:0], 1'b0};
               div_start = 1'b1;
               state_in = S_INTD;
            end
         end
         S_INTD: begin
            if (div_done) begin
               interval_in = (div_quot > 64'(INTERVAL_MAX)) ? INTERVAL_MAX
                                                            : div_quot[19:0];
               ivalid_in = 1'b1;
               pulse_in = stopped_ff ? 1'b0 : ~pulse_ff;
               dir_in = stopped_ff ? 1'b0 : (actual_ff > 0);
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in.pulse_level = pulse_ff;
               rsp_in.direction_level = dir_ff;
               rsp_in.edge_interval_us = interval_ff;
               rsp_in.interval_valid = ivalid_ff;
               rsp_in.is_stopped = stopped_ff;
               rsp_in.at_max_velocity = abs_actual >= {1'b0, maxv_ff};
               rsp_in.actual_velocity = actual_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ppr_ff <= 16'd1000;
         maxv_ff <= 31'd655360;
         minf_ff <= 16'd100;
         accel_ff <= 31'd655360;
         state_ff <= S_IDLE;
         target_ff <= '0;
         actual_ff <= '0;
         pulse_ff <= 1'b0;
         dir_ff <= 1'b0;
         stopped_ff <= 1'b1;
         last_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_PPR:      ppr_ff <= csr_write_data[15:0];
               CSR_MAX_VEL:  maxv_ff <= csr_write_data;
               CSR_MIN_FREQ: minf_ff <= csr_write_data[15:0];
               CSR_ACCEL:    accel_ff <= csr_write_data;
               default:      ppr_ff <= ppr_ff;
            endcase
         end
         state_ff <= state_in;
         target_ff <= target_in;
         actual_ff <= actual_in;
         pulse_ff <= pulse_in;
         dir_ff <= dir_in;
         stopped_ff <= stopped_in;
         last_ff <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      minv_ff <= minv_in;
      interval_ff <= interval_in;
      ivalid_ff <= ivalid_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `SDP_ASSERT_NOW(a_stop_zero_vel, clock, reset,
      rsp_valid_ff && rsp_ff.is_stopped, rsp_ff.actual_velocity == 0)
   `SDP_ASSERT_NOW(a_stop_pulse_low, clock, reset,
      stopped_ff, !pulse_ff && !dir_ff)
   `SDP_ASSERT_NEXT(a_accept_starts, clock, reset,
      req_valid && !req_stall, state_ff == S_MINV)

endmodule
